// ===== rtl/hws_pkg.sv =====
`default_nettype none

package hws_pkg;

  // Default sizes of the histogram.
  localparam int unsigned MaxEntriesDef = 64;
  localparam int unsigned ValueWidthDef = 32;
  localparam int unsigned CountWidthDef = 32;

  // Width of the value, pick and total fields on the ports.
  localparam int unsigned FieldWidth = 32;

  // Depth of the queue between the front and the back.
  localparam int unsigned QueueDepth = 2;

  typedef enum logic {
    OP_OBSERVE = 1'b0,
    OP_DRAW    = 1'b1
  } op_kind_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_RANGE = 2'd2,
    ST_FULL  = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_WALK,
    BK_EMIT
  } back_state_e;

  // One classified item as it travels from the front to the back.
  typedef struct packed {
    op_kind_e              kind;
    logic                  pick_zero;
    logic [FieldWidth-1:0] sample_value;
    logic [FieldWidth-1:0] pick;
  } op_t;

endpackage

`default_nettype wire

// ===== rtl/hws_ram.sv =====
`default_nettype none

module hws_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== rtl/hws_front.sv =====
`default_nettype none

module hws_front
  import hws_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire logic                  req_type_i,
  input  wire logic [FieldWidth-1:0] sample_value_i,
  input  wire logic [FieldWidth-1:0] pick_i,
  output logic                       op_valid_o,
  output op_t                        op_o,
  input  wire logic                  op_pop_i
);

  localparam int unsigned PtrW = $clog2(QueueDepth);
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  op_t              slot_q [QueueDepth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             push, pop;
  op_t              op_new;

  // Classify the incoming item.
  always_comb begin
    op_new              = '0;
    op_new.sample_value = sample_value_i;
    op_new.pick         = pick_i;
    op_new.pick_zero    = (pick_i == '0);
    case (req_type_i)
      OP_OBSERVE: op_new.kind = OP_OBSERVE;
      OP_DRAW:    op_new.kind = OP_DRAW;
      default:    op_new.kind = OP_OBSERVE;
    endcase
  end

  assign in_stall_o = (cnt_q == CntW'(QueueDepth));
  assign push       = in_valid_i && !in_stall_o;
  assign op_valid_o = (cnt_q != '0);
  assign pop        = op_pop_i && op_valid_o;
  assign op_o       = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push && !pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (pop && !push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= op_new;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/hws_back.sv =====
`default_nettype none

module hws_back
  import hws_pkg::*;
#(
  parameter int unsigned MaxEntries = MaxEntriesDef,
  parameter int unsigned ValueWidth = ValueWidthDef,
  parameter int unsigned CountWidth = CountWidthDef
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  op_valid_i,
  input  wire op_t                   op_i,
  output logic                       op_pop_o,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output logic [FieldWidth-1:0]      drawn_value_o,
  output logic [1:0]                 status_o,
  output logic [FieldWidth-1:0]      running_total_o
);

  localparam int unsigned AW = $clog2(MaxEntries);
  localparam int unsigned UW = $clog2(MaxEntries + 1);
  localparam int unsigned XW = (ValueWidth > FieldWidth) ? ValueWidth : FieldWidth;
  localparam int unsigned PW = (CountWidth > FieldWidth) ? CountWidth : FieldWidth;

  back_state_e            state_q, state_d;
  logic [UW-1:0]          used_q, used_d;
  logic [CountWidth-1:0]  total_q, total_d;
  logic [UW-1:0]          iss_q, iss_d;
  logic                   chk_vld_q, chk_vld_d;
  logic [AW-1:0]          chk_idx_q, chk_idx_d;
  op_kind_e               kind_q, kind_d;
  logic [ValueWidth-1:0]  val_q, val_d;
  logic [CountWidth-1:0]  rem_q, rem_d;
  logic [ValueWidth-1:0]  res_value_q, res_value_d;
  status_e                res_status_q, res_status_d;
  logic                   out_vld_q, out_vld_d;
  logic [FieldWidth-1:0]  out_value_q, out_value_d;
  status_e                out_status_q, out_status_d;
  logic [FieldWidth-1:0]  out_total_q, out_total_d;

  logic                   rd_en;
  logic [ValueWidth-1:0]  val_rd;
  logic [CountWidth-1:0]  cnt_rd;
  logic                   val_we, cnt_we;
  logic [AW-1:0]          waddr;
  logic [ValueWidth-1:0]  val_wdata;
  logic [CountWidth-1:0]  cnt_wdata;

  logic [XW-1:0]          sv_ext;
  logic [ValueWidth-1:0]  sv_new;
  logic [PW-1:0]          pick_ext;
  logic [PW-1:0]          total_ext;
  logic [XW-1:0]          res_value_ext;
  logic                   total_sat;
  logic                   hit, last;

  assign sv_ext    = XW'(op_i.sample_value);
  assign sv_new    = sv_ext[ValueWidth-1:0];
  assign pick_ext  = PW'(op_i.pick);
  assign total_ext = PW'(total_q);
  assign total_sat = &total_q;
  assign res_value_ext = XW'(res_value_q);

  assign rd_en = (state_q == BK_WALK) && (iss_q < used_q);
  assign hit   = (kind_q == OP_DRAW) ? (rem_q <= cnt_rd) : (val_rd == val_q);
  assign last  = ((UW'(chk_idx_q) + UW'(1)) == used_q);

  hws_ram #(
    .Width (ValueWidth),
    .Depth (MaxEntries)
  ) u_val_ram (
    .clk_i   (clk_i),
    .we_i    (val_we),
    .waddr_i (waddr),
    .wdata_i (val_wdata),
    .re_i    (rd_en),
    .raddr_i (iss_q[AW-1:0]),
    .rdata_o (val_rd)
  );

  hws_ram #(
    .Width (CountWidth),
    .Depth (MaxEntries)
  ) u_cnt_ram (
    .clk_i   (clk_i),
    .we_i    (cnt_we),
    .waddr_i (waddr),
    .wdata_i (cnt_wdata),
    .re_i    (rd_en),
    .raddr_i (iss_q[AW-1:0]),
    .rdata_o (cnt_rd)
  );

  always_comb begin
    state_d      = state_q;
    used_d       = used_q;
    total_d      = total_q;
    iss_d        = iss_q;
    chk_vld_d    = chk_vld_q;
    chk_idx_d    = chk_idx_q;
    kind_d       = kind_q;
    val_d        = val_q;
    rem_d        = rem_q;
    res_value_d  = res_value_q;
    res_status_d = res_status_q;
    out_vld_d    = out_vld_q;
    out_value_d  = out_value_q;
    out_status_d = out_status_q;
    out_total_d  = out_total_q;
    op_pop_o     = 1'b0;
    val_we       = 1'b0;
    cnt_we       = 1'b0;
    waddr        = used_q[AW-1:0];
    val_wdata    = val_q;
    cnt_wdata    = CountWidth'(1);

    if (out_vld_q && !out_stall_i) begin
      out_vld_d = 1'b0;
    end

    case (state_q)
      BK_IDLE: begin
        if (op_valid_i) begin
          op_pop_o     = 1'b1;
          kind_d       = op_i.kind;
          val_d        = sv_new;
          rem_d        = pick_ext[CountWidth-1:0];
          res_value_d  = '0;
          res_status_d = ST_OK;
          iss_d        = '0;
          chk_vld_d    = 1'b0;
          state_d      = BK_EMIT;
          if (op_i.kind == OP_DRAW) begin
            if (total_q == '0) begin
              res_status_d = ST_EMPTY;
            end else if (op_i.pick_zero || (pick_ext > total_ext)) begin
              res_status_d = ST_RANGE;
            end else begin
              state_d = BK_WALK;
            end
          end else if (!total_sat) begin
            if (used_q == '0) begin
              // First value of an empty table goes straight into entry zero.
              val_we    = 1'b1;
              cnt_we    = 1'b1;
              waddr     = '0;
              val_wdata = sv_new;
              used_d    = UW'(1);
              total_d   = total_q + CountWidth'(1);
            end else begin
              state_d = BK_WALK;
            end
          end
        end
      end

      BK_WALK: begin
        if (rd_en) begin
          iss_d = iss_q + UW'(1);
        end
        chk_vld_d = rd_en;
        chk_idx_d = iss_q[AW-1:0];
        if (chk_vld_q) begin
          if (hit) begin
            state_d   = BK_EMIT;
            chk_vld_d = 1'b0;
            if (kind_q == OP_DRAW) begin
              res_value_d = val_rd;
            end else begin
              cnt_we    = 1'b1;
              waddr     = chk_idx_q;
              cnt_wdata = (&cnt_rd) ? cnt_rd : cnt_rd + CountWidth'(1);
              total_d   = total_q + CountWidth'(1);
            end
          end else if (last) begin
            state_d   = BK_EMIT;
            chk_vld_d = 1'b0;
            if (kind_q == OP_DRAW) begin
              res_status_d = ST_RANGE;
            end else if (used_q == UW'(MaxEntries)) begin
              res_status_d = ST_FULL;
            end else begin
              val_we  = 1'b1;
              cnt_we  = 1'b1;
              used_d  = used_q + UW'(1);
              total_d = total_q + CountWidth'(1);
            end
          end else if (kind_q == OP_DRAW) begin
            rem_d = rem_q - cnt_rd;
          end
        end
      end

      BK_EMIT: begin
        if (!out_vld_q || !out_stall_i) begin
          out_vld_d    = 1'b1;
          out_value_d  = res_value_ext[FieldWidth-1:0];
          out_status_d = res_status_q;
          out_total_d  = total_ext[FieldWidth-1:0];
          state_d      = BK_IDLE;
        end
      end

      default: begin
        state_d = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= BK_IDLE;
      used_q    <= '0;
      total_q   <= '0;
      iss_q     <= '0;
      chk_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      used_q    <= used_d;
      total_q   <= total_d;
      iss_q     <= iss_d;
      chk_vld_q <= chk_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    chk_idx_q    <= chk_idx_d;
    kind_q       <= kind_d;
    val_q        <= val_d;
    rem_q        <= rem_d;
    res_value_q  <= res_value_d;
    res_status_q <= res_status_d;
    out_value_q  <= out_value_d;
    out_status_q <= out_status_d;
    out_total_q  <= out_total_d;
  end

  assign out_valid_o     = out_vld_q;
  assign drawn_value_o   = out_value_q;
  assign status_o        = out_status_q;
  assign running_total_o = out_total_q;

endmodule

`default_nettype wire

// ===== rtl/histogram_weighted_sampler_unit.sv =====
// Weighted sampler over an empirical histogram. An observe item (req_type 0) records a
// value: the table is searched in insertion order, a matching entry gets its count raised
// by one, and an unseen value is appended with count one; the running total rises by one
// either way. A draw item (req_type 1) carries a pick in 1..total and returns the value of
// the entry in which the pick falls when the counts are laid end to end in insertion order.
// Every item gives exactly one result item with drawn_value, status and running_total,
// the total as it stands after the item. Status 0 is ok, 1 a draw on an empty table, 2 a
// pick of zero or above the total, and 3 an unseen value observed while the table is full,
// which is then dropped and not counted. Once the total reaches its maximum, further
// observes are ignored with status 0, so no count can overflow. An item that walks the
// table visits at most used entries, where used is the number of distinct values stored:
// the values and counts sit in two single-port-read memories, and the back end reads one
// entry per cycle through their registered read ports. Items that need no walk (errors,
// a saturated total, the first value) skip the walk entirely. A two-item queue in front
// keeps accepting items while the back end is busy, and the result register lets the next
// item start while an earlier result is still waiting to be taken. Entries hold no reset
// value; only entries already written are ever read.
`default_nettype none

module histogram_weighted_sampler_unit
  import hws_pkg::*;
#(
  parameter int unsigned MaxEntries = MaxEntriesDef,
  parameter int unsigned ValueWidth = ValueWidthDef,
  parameter int unsigned CountWidth = CountWidthDef
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire logic                  req_type_i,
  input  wire logic [FieldWidth-1:0] sample_value_i,
  input  wire logic [FieldWidth-1:0] pick_i,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output logic [FieldWidth-1:0]      drawn_value_o,
  output logic [1:0]                 status_o,
  output logic [FieldWidth-1:0]      running_total_o
);

  // Classified items travel from the front queue to the back end.
  op_t  op;
  logic op_valid;
  logic op_pop;

  hws_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .req_type_i     (req_type_i),
    .sample_value_i (sample_value_i),
    .pick_i         (pick_i),
    .op_valid_o     (op_valid),
    .op_o           (op),
    .op_pop_i       (op_pop)
  );

  // The back end owns the table, the totals and the result register.
  hws_back #(
    .MaxEntries (MaxEntries),
    .ValueWidth (ValueWidth),
    .CountWidth (CountWidth)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .op_valid_i      (op_valid),
    .op_i            (op),
    .op_pop_o        (op_pop),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .drawn_value_o   (drawn_value_o),
    .status_o        (status_o),
    .running_total_o (running_total_o)
  );

endmodule

`default_nettype wire

// ===== test/histogram_weighted_sampler_unit_tb.sv =====
`timescale 1ns / 100ps

// Testbench for the histogram weighted sampler. Observe and draw items go in through
// the valid/stall input channel, and every accepted item is run through a behavioral
// copy of the histogram kept here. That copy gives the drawn value, the status and the
// running total that the block must return. The result channel is checked field by
// field against the oldest expected result, in order.
module histogram_weighted_sampler_unit_tb;
  import hws_pkg::*;

  localparam int unsigned CycleLimit = 1_000_000;
  localparam int unsigned HoldCycles = 400;
  // The tail leaves room for a walk over every stored entry.
  localparam int unsigned TailCycles = MaxEntriesDef + 16;
  localparam logic [CountWidthDef-1:0] CountMax = '1;

  // One result item as the block should present it.
  typedef struct packed {
    logic [FieldWidth-1:0] drawn;
    status_e               status;
    logic [FieldWidth-1:0] total;
  } sample_result_t;

  logic                  clk;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_stall_o;
  logic                  req_type_i;
  logic [FieldWidth-1:0] sample_value_i;
  logic [FieldWidth-1:0] pick_i;
  logic                  out_valid_o;
  logic                  out_stall_i;
  logic [FieldWidth-1:0] drawn_value_o;
  logic [1:0]            status_o;
  logic [FieldWidth-1:0] running_total_o;

  // Our own copy of the histogram: values and counts in insertion order.
  logic [ValueWidthDef-1:0] hist_value [MaxEntriesDef];
  logic [CountWidthDef-1:0] hist_count [MaxEntriesDef];
  int unsigned              hist_used;
  logic [CountWidthDef-1:0] hist_total;

  sample_result_t pending_results [$];
  sample_result_t oldest_result;

  int unsigned mismatches;
  int unsigned cycle_count;
  int unsigned send_idle_pct;
  int unsigned stall_pct;
  int unsigned hold_left;

  histogram_weighted_sampler_unit u_dut (
    .clk_i           (clk),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .req_type_i      (req_type_i),
    .sample_value_i  (sample_value_i),
    .pick_i          (pick_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .drawn_value_o   (drawn_value_o),
    .status_o        (status_o),
    .running_total_o (running_total_o)
  );

  initial begin
    clk = 1'b0;
  end

  always #4 clk = ~clk;

  // Every input gets a known value at time zero.
  initial begin
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    req_type_i     = OP_OBSERVE;
    sample_value_i = '0;
    pick_i         = '0;
    out_stall_i    = 1'b0;
    hist_used      = 0;
    hist_total     = '0;
    mismatches     = 0;
    cycle_count    = 0;
    send_idle_pct  = 0;
    stall_pct      = 0;
    hold_left      = 0;
  end

  // Applies one accepted item to the histogram copy and returns the result that the
  // block must give for it. The total saturating at all ones cannot be reached in a run
  // of this length, but it is handled so that the copy stays faithful.
  function automatic sample_result_t histogram_predict(input op_kind_e kind,
                                                       input logic [FieldWidth-1:0] value,
                                                       input logic [FieldWidth-1:0] pick);
    sample_result_t           r;
    logic [CountWidthDef-1:0] left;
    bit                       found;
    int unsigned              idx;
    r.drawn  = '0;
    r.status = ST_OK;
    found    = 1'b0;
    if (kind == OP_OBSERVE) begin
      if (hist_total != CountMax) begin
        for (idx = 0; idx < hist_used && !found; idx++) begin
          if (hist_value[idx] == value) begin
            found = 1'b1;
            if (hist_count[idx] != CountMax) begin
              hist_count[idx]++;
            end
            hist_total++;
          end
        end
        if (!found) begin
          if (hist_used >= MaxEntriesDef) begin
            // Unseen value with no room left: dropped and not counted.
            r.status = ST_FULL;
          end else begin
            hist_value[hist_used] = value;
            hist_count[hist_used] = 1;
            hist_used++;
            hist_total++;
          end
        end
      end
    end else if (hist_total == 0) begin
      r.status = ST_EMPTY;
    end else if (pick == 0 || pick > hist_total) begin
      r.status = ST_RANGE;
    end else begin
      // Lay the counts end to end and find the entry the pick falls into.
      left     = pick;
      r.status = ST_RANGE;
      for (idx = 0; idx < hist_used && !found; idx++) begin
        if (left <= hist_count[idx]) begin
          found    = 1'b1;
          r.drawn  = hist_value[idx];
          r.status = ST_OK;
        end else begin
          left -= hist_count[idx];
        end
      end
    end
    r.total = hist_total;
    return r;
  endfunction

  task automatic report_mismatch(input string field, input logic [FieldWidth-1:0] got,
                                 input logic [FieldWidth-1:0] want);
    begin
      $display("%0t: mismatch on %s: got %h, expected %h", $time, field, got, want);
      mismatches++;
    end
  endtask

  // Offers one item, with random idle cycles ahead of it, and holds it until the block
  // takes it. The expected result is worked out at the accepting edge, so the histogram
  // copy always sees items in the order the block does. Valid stays high from one item
  // to the next when no idle cycle falls between them.
  task automatic send_item(input op_kind_e kind, input logic [FieldWidth-1:0] value,
                           input logic [FieldWidth-1:0] pick);
    begin
      @(negedge clk);
      while ($urandom_range(99) < send_idle_pct) begin
        in_valid_i = 1'b0;
        @(negedge clk);
      end
      in_valid_i     = 1'b1;
      req_type_i     = kind;
      sample_value_i = value;
      pick_i         = pick;
      do begin
        @(posedge clk);
      end while (in_stall_o);
      pending_results.insert(pending_results.size(), histogram_predict(kind, value, pick));
    end
  endtask

  // Builds one random item from the current histogram. Most draws carry a pick inside
  // 1..total so that the walk goes deep; the rest are zero, one past the total, or any
  // 32-bit number. Observes mostly repeat a stored value, and only add a fresh one while
  // fewer than distinct_cap values are stored.
  task automatic send_random_item(input int unsigned new_pct, input int unsigned distinct_cap);
    logic [FieldWidth-1:0] value;
    logic [FieldWidth-1:0] pick;
    op_kind_e              kind;
    begin
      value = $urandom;
      pick  = $urandom;
      if ($urandom_range(99) < 45) begin
        kind = OP_DRAW;
        if (hist_total != 0 && $urandom_range(99) < 85) begin
          pick = $urandom_range(hist_total, 1);
        end else begin
          case ($urandom_range(2))
            0: pick = '0;
            1: pick = hist_total + 1;
            default: ;
          endcase
        end
      end else begin
        kind = OP_OBSERVE;
        if (hist_used != 0 &&
            (hist_used >= distinct_cap || $urandom_range(99) >= new_pct)) begin
          value = hist_value[$urandom_range(hist_used - 1)];
        end
      end
      send_item(kind, value, pick);
    end
  endtask

  task automatic run_phase(input int unsigned items, input int unsigned idle_pct,
                           input int unsigned stall_chance, input int unsigned new_pct,
                           input int unsigned distinct_cap);
    begin
      send_idle_pct = idle_pct;
      stall_pct     = stall_chance;
      repeat (items) send_random_item(new_pct, distinct_cap);
    end
  endtask

  // Drops valid and waits until every expected result has come back.
  task automatic wait_for_drain;
    begin
      @(negedge clk);
      in_valid_i = 1'b0;
      while (pending_results.size() != 0) @(posedge clk);
    end
  endtask

  // Empty table, out-of-range picks, the extreme values and picks on both edges of each
  // entry. The ignored field of each item carries all zeros, all ones or another pattern to show it has no effect.
  task automatic test_directed;
    begin
      send_idle_pct = 0;
      stall_pct     = 0;
      send_item(OP_DRAW, 32'hFFFF_FFFF, 32'd1);
      send_item(OP_DRAW, 32'h0000_0000, 32'd0);
      send_item(OP_OBSERVE, 32'h0000_0000, 32'hFFFF_FFFF);
      send_item(OP_OBSERVE, 32'hFFFF_FFFF, 32'h0000_0000);
      send_item(OP_OBSERVE, 32'h0000_0000, 32'h0000_0000);
      send_item(OP_DRAW, 32'hFFFF_FFFF, 32'd0);
      send_item(OP_DRAW, 32'hFFFF_FFFF, 32'd1);
      send_item(OP_DRAW, 32'hFFFF_FFFF, 32'd2);
      send_item(OP_DRAW, 32'h0000_0000, 32'd3);
      send_item(OP_DRAW, 32'h0000_0000, 32'd4);
      send_item(OP_DRAW, 32'h0000_0000, 32'hFFFF_FFFF);
      send_item(OP_OBSERVE, 32'hA5A5_5A5A, 32'hFFFF_FFFF);
      send_item(OP_OBSERVE, 32'h5A5A_A5A5, 32'h0000_0000);
      send_item(OP_DRAW, 32'h0000_0000, 32'd5);
      send_item(OP_DRAW, 32'hFFFF_FFFF, 32'd4);
      send_item(OP_OBSERVE, 32'hFFFF_FFFF, 32'h8000_0001);
    end
  endtask

  // Random traffic while the table holds at most 48 values, one phase per idling mix.
  task automatic test_random_walks;
    begin
      run_phase(150, 0, 0, 30, 48);
      run_phase(150, 50, 0, 30, 48);
      run_phase(150, 0, 50, 30, 48);
      run_phase(150, 30, 30, 30, 48);
    end
  endtask

  // The receiver holds off for a long stretch while items keep coming, so the queue in
  // front of the walker fills and the block has to stall its input.
  task automatic test_input_backpressure;
    begin
      send_idle_pct = 0;
      stall_pct     = 0;
      hold_left     = HoldCycles;
      repeat (30) send_random_item(20, 48);
    end
  endtask

  // The sender stops until the block has nothing left in flight, then resumes.
  task automatic test_drain_pause;
    begin
      run_phase(10, 0, 0, 20, 48);
      wait_for_drain();
      run_phase(10, 0, 0, 20, 48);
    end
  endtask

  // Fills the table to its last entry, then observes unseen values that must be dropped,
  // with draws at the first and last pick and one past the total mixed in.
  task automatic test_table_full;
    begin
      send_idle_pct = 10;
      stall_pct     = 10;
      while (hist_used < MaxEntriesDef) begin
        send_item(OP_OBSERVE, $urandom, $urandom);
        if ($urandom_range(3) == 0) begin
          send_item(OP_DRAW, $urandom, $urandom_range(hist_total, 1));
        end
      end
      repeat (8) begin
        send_item(OP_OBSERVE, $urandom, $urandom);
        send_item(OP_DRAW, $urandom, hist_total);
      end
      send_item(OP_DRAW, $urandom, hist_total + 1);
      send_item(OP_DRAW, $urandom, 32'd1);
      send_item(OP_OBSERVE, hist_value[MaxEntriesDef-1], $urandom);
    end
  endtask

  // Random traffic against a full table: every unseen value walks the whole table, and fresh
  // values keep coming back as full.
  task automatic test_random_full_table;
    begin
      run_phase(120, 0, 0, 20, MaxEntriesDef + 1);
      run_phase(120, 50, 0, 20, MaxEntriesDef + 1);
      run_phase(120, 0, 50, 20, MaxEntriesDef + 1);
      run_phase(120, 30, 30, 20, MaxEntriesDef + 1);
    end
  endtask

  // Receiver stall, driven at the falling edge. A long hold-off, when one is asked for,
  // is counted down here and takes priority over the random stall.
  always @(negedge clk) begin
    if (hold_left != 0) begin
      out_stall_i <= 1'b1;
      hold_left   <= hold_left - 1;
    end else begin
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  // Each result taken by the receiver is matched against the oldest expected one.
  always @(posedge clk) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result, running_total", running_total_o, '0);
      end else begin
        oldest_result = pending_results.pop_front();
        if (drawn_value_o !== oldest_result.drawn) begin
          report_mismatch("drawn_value", drawn_value_o, oldest_result.drawn);
        end
        if (status_o !== oldest_result.status) begin
          report_mismatch("status", FieldWidth'(status_o), FieldWidth'(oldest_result.status));
        end
        if (running_total_o !== oldest_result.total) begin
          report_mismatch("running_total", running_total_o, oldest_result.total);
        end
      end
    end
  end

  // A hung handshake or a lost result ends the run here.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_ni = 1'b1;

    test_directed();
    test_random_walks();
    test_input_backpressure();
    test_drain_pause();
    test_table_full();
    test_random_full_table();

    wait_for_drain();
    // Give a stray extra result time to show up before the verdict.
    repeat (TailCycles) @(posedge clk);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
